/* sv/rru_pkg.sv */
package rru_pkg;

   localparam int NODE_W = 6;

   localparam logic OP_UNION = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic KIND_UNION = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SOURCE,
      ST_TARGET,
      ST_PUSH
   } state_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_INIT,
      MEM_READ_REQ,
      MEM_READ_TARGET,
      MEM_WRITE_TARGET
   } mem_cmd_type;

   typedef struct packed {
      mem_cmd_type mem;
      logic        capture;
      logic        step_source;
      logic        step_target;
      logic        push;
      logic        init_next;
   } ctrl_cmd_type;

   typedef struct packed {
      logic init_done;
      logic item_query;
      logic item_last;
      logic out_free;
   } ctrl_status_type;

endpackage

/* sv/rru_if.sv */
interface rru_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [rru_pkg::NODE_W-1:0]  target;
   logic [rru_pkg::NODE_W-1:0]  source_node;
   logic                        source_valid;
   logic                        last;

   modport source (output valid, output op, output target, output source_node,
                   output source_valid, output last, input ready);
   modport sink (input valid, input op, input target, input source_node,
                 input source_valid, input last, output ready);
endinterface

interface rru_rsp_if;
   logic valid;
   logic ready;
   logic kind;
   logic changed;
   logic reachable;

   modport source (output valid, output kind, output changed, output reachable,
                   input ready);
   modport sink (input valid, input kind, input changed, input reachable,
                 output ready);
endinterface

/* sv/reachability_row_union.sv */
// channel    dir  payload                                        handshake
// req_chan   in   op, target, source_node, source_valid, last    valid / ready
// rsp_chan   out  kind, changed, reachable                       valid / ready
//
// a union item that is not last does a row read, then an accumulate; a query
// passes ST_IDLE, ST_SOURCE and ST_PUSH, and a finishing union also ST_TARGET
// (second read and write of the target row through the single row memory
// port); ST_PUSH waits until rsp_chan takes the previous result; after reset
// a sweep writes the MAX_NODES identity rows; no request is taken until it ends
// a held result waits in the output register while the next request is taken
module reachability_row_union #(
   parameter int MAX_NODES = 64
) (
   input logic      clock,
   input logic      reset,
   rru_req_if.sink  req_chan,
   rru_rsp_if.source rsp_chan
);

   rru_pkg::ctrl_cmd_type    cmd;
   rru_pkg::ctrl_status_type status;

   rru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rru_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_chan.op),
      .req_target       (req_chan.target),
      .req_source       (req_chan.source_node),
      .req_source_valid (req_chan.source_valid),
      .req_last         (req_chan.last),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_kind         (rsp_chan.kind),
      .rsp_changed      (rsp_chan.changed),
      .rsp_reachable    (rsp_chan.reachable)
   );

endmodule

/* sv/rru_ctrl.sv */
module rru_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rru_pkg::ctrl_status_type status,
   output rru_pkg::ctrl_cmd_type    cmd
);

   rru_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rru_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.mem         = rru_pkg::MEM_NONE;
      case (state_ff)
         rru_pkg::ST_CLEAR: begin
            cmd.mem       = rru_pkg::MEM_INIT;
            cmd.init_next = 1'b1;
            if (status.init_done) begin
               state_in = rru_pkg::ST_IDLE;
            end
         end
         rru_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.mem     = rru_pkg::MEM_READ_REQ;
               state_in    = rru_pkg::ST_SOURCE;
            end
         end
         rru_pkg::ST_SOURCE: begin
            cmd.step_source = 1'b1;
            if (status.item_query) begin
               state_in = rru_pkg::ST_PUSH;
            end else if (status.item_last) begin
               // old target row is needed to build the new one
               cmd.mem  = rru_pkg::MEM_READ_TARGET;
               state_in = rru_pkg::ST_TARGET;
            end else begin
               state_in = rru_pkg::ST_IDLE;
            end
         end
         rru_pkg::ST_TARGET: begin
            cmd.step_target = 1'b1;
            cmd.mem         = rru_pkg::MEM_WRITE_TARGET;
            state_in        = rru_pkg::ST_PUSH;
         end
         rru_pkg::ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = rru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rru_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/rru_datapath.sv */
module rru_datapath #(
   parameter int MAX_NODES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rru_pkg::ctrl_cmd_type       cmd,
   output rru_pkg::ctrl_status_type    status,
   input  logic                        req_op,
   input  logic [rru_pkg::NODE_W-1:0]  req_target,
   input  logic [rru_pkg::NODE_W-1:0]  req_source,
   input  logic                        req_source_valid,
   input  logic                        req_last,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_kind,
   output logic                        rsp_changed,
   output logic                        rsp_reachable
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int IW = (AW > rru_pkg::NODE_W) ? AW : rru_pkg::NODE_W;
   localparam logic [IW:0] NODE_LIMIT = (IW + 1)'(MAX_NODES);
   localparam logic [AW-1:0] LAST_ROW = AW'(MAX_NODES - 1);

   logic [MAX_NODES-1:0] rows [MAX_NODES];
   logic [MAX_NODES-1:0] rd_row_ff;

   logic                        op_ff;
   logic [rru_pkg::NODE_W-1:0]  tgt_ff;
   logic [rru_pkg::NODE_W-1:0]  src_ff;
   logic                        sv_ff;
   logic                        last_ff;

   logic [MAX_NODES-1:0] acc_ff;
   logic                 seen_ff;
   logic [AW-1:0]        init_cnt_ff;

   logic res_kind_ff, res_changed_ff, res_reachable_ff;
   logic out_valid_ff, out_kind_ff, out_changed_ff, out_reachable_ff;

   logic [IW-1:0] tgt_ext, src_ext, req_addr_ext;
   logic [AW-1:0] tgt_idx, src_idx;
   logic          t_ok, s_ok;
   logic [MAX_NODES-1:0] fresh;
   logic [AW-1:0]        mem_addr;
   logic [MAX_NODES-1:0] mem_wdata;
   logic                 mem_we, mem_re;

   assign tgt_ext      = IW'(tgt_ff);
   assign src_ext      = IW'(src_ff);
   assign req_addr_ext = IW'((req_op == rru_pkg::OP_QUERY) ? req_target : req_source);
   assign tgt_idx      = tgt_ext[AW-1:0];
   assign src_idx      = src_ext[AW-1:0];
   assign t_ok         = {1'b0, tgt_ext} < NODE_LIMIT;
   assign s_ok         = {1'b0, src_ext} < NODE_LIMIT;

   assign fresh = (seen_ff ? rd_row_ff : '0) | acc_ff
                  | ({{(MAX_NODES-1){1'b0}}, 1'b1} << tgt_idx);

   always_comb begin
      mem_addr  = tgt_idx;
      mem_wdata = fresh;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      case (cmd.mem)
         rru_pkg::MEM_INIT: begin
            mem_addr  = init_cnt_ff;
            mem_wdata = {{(MAX_NODES-1){1'b0}}, 1'b1} << init_cnt_ff;
            mem_we    = 1'b1;
         end
         rru_pkg::MEM_READ_REQ: begin
            mem_addr = req_addr_ext[AW-1:0];
            mem_re   = 1'b1;
         end
         rru_pkg::MEM_READ_TARGET: begin
            mem_re = 1'b1;
         end
         rru_pkg::MEM_WRITE_TARGET: begin
            mem_we = t_ok;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rows[mem_addr] <= mem_wdata;
      end else if (mem_re) begin
         rd_row_ff <= rows[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         tgt_ff  <= req_target;
         src_ff  <= req_source;
         sv_ff   <= req_source_valid;
         last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         seen_ff     <= 1'b0;
         init_cnt_ff <= '0;
      end else begin
         if (cmd.init_next && init_cnt_ff != LAST_ROW) begin
            init_cnt_ff <= init_cnt_ff + AW'(1);
         end
         if (cmd.step_source && op_ff == rru_pkg::OP_UNION && sv_ff) begin
            if (src_ff == tgt_ff) begin
               seen_ff <= 1'b1;
            end else if (s_ok) begin
               acc_ff <= acc_ff | rd_row_ff;
            end
         end
         if (cmd.step_target) begin
            acc_ff  <= '0;
            seen_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_source) begin
         res_kind_ff      <= rru_pkg::KIND_QUERY;
         res_changed_ff   <= 1'b0;
         res_reachable_ff <= t_ok && s_ok && rd_row_ff[src_idx];
      end else if (cmd.step_target) begin
         res_kind_ff      <= rru_pkg::KIND_UNION;
         res_changed_ff   <= t_ok && (fresh != rd_row_ff);
         res_reachable_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_kind_ff      <= res_kind_ff;
         out_changed_ff   <= res_changed_ff;
         out_reachable_ff <= res_reachable_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_changed   = out_changed_ff;
   assign rsp_reachable = out_reachable_ff;

   assign status.init_done  = (init_cnt_ff == LAST_ROW);
   assign status.item_query = (op_ff == rru_pkg::OP_QUERY);
   assign status.item_last  = last_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;

endmodule
